/* rtl/oate_pkg.sv */
// ----------------------------------------------------------------------------
// oate_pkg
// Shared types, constants and helpers for the ordered array table engine.
// ----------------------------------------------------------------------------
package oate_pkg;

  localparam int CAPACITY = 128;
  localparam int IW       = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CW       = $clog2(CAPACITY + 1);
  localparam int PW       = ((CW > 8) ? CW : 8) + 1;

  typedef logic signed [31:0] word_t;

  typedef enum logic [2:0] {
    REQ_CLEAR  = 3'd0,
    REQ_INSERT = 3'd1,
    REQ_DELETE = 3'd2,
    REQ_SEARCH = 3'd3,
    REQ_READ   = 3'd4
  } req_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_RANGE    = 2'd1,
    STS_FULL     = 2'd2,
    STS_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL,
    CMD_ROT
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } fsm_t;

  typedef struct packed {
    cell_cmd_t       cmd;
    logic [IW-1:0]   pidx;
    logic [IW-1:0]   last;
    word_t           data;
  } cell_ctl_t;

  function automatic logic [7:0] to_byte(input logic [CW-1:0] v);
    logic [CW+7:0] t;
    t = {8'b0, v};
    return t[7:0];
  endfunction

endpackage

/* rtl/oate_in_if.sv */
// ----------------------------------------------------------------------------
// oate_in_if
// Request channel: valid/ready handshake with request payload.
// ----------------------------------------------------------------------------
interface oate_in_if import oate_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  req_type;
  logic [7:0]  position;
  word_t       data_value;

  modport source (output valid, output req_type, output position, output data_value,
                  input ready);
  modport sink   (input valid, input req_type, input position, input data_value,
                  output ready);
endinterface

/* rtl/oate_out_if.sv */
// ----------------------------------------------------------------------------
// oate_out_if
// Result channel: valid/ready handshake with result payload.
// ----------------------------------------------------------------------------
interface oate_out_if import oate_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [7:0]  found_position;
  word_t       read_value;
  logic [7:0]  element_count;

  modport source (output valid, output status, output found_position,
                  output read_value, output element_count, input ready);
  modport sink   (input valid, input status, input found_position,
                  input read_value, input element_count, output ready);
endinterface

/* rtl/ordered_array_table_engine.sv */
// ----------------------------------------------------------------------------
// ordered_array_table_engine
// Ordered list of signed 32-bit entries held in a chain of cells.
//
// Request beats arrive on in_bus (clear, insert, delete, search, read with
// position and data_value); one result beat per request leaves on out_bus
// with status, found_position, read_value and element_count.
// Clear, insert, delete, unused codes, errors and a search of an empty list:
// insert and delete shift the cells as the request beat is taken, and the
// result is valid the cycle after the request beat.
// Search of a non-empty list and in-range read with n entries held: the cell
// ring rotates once through all n entries, each entry passing the head cell
// in list order; the result is registered as the last entry passes and the
// list is back in place.
// A new request is taken whenever the sequencer is idle and the result
// register is empty or being drained in the same cycle, so list updates
// sustain one beat per cycle while out_bus takes results, and a scanning
// request holds off the input until its rotation ends.
// Reset empties the list (count zero) and drops any pending result.
// While out_bus is stalled the result holds and in_bus.ready stays low.
// ----------------------------------------------------------------------------
module ordered_array_table_engine import oate_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  oate_in_if.sink     in_bus,
  oate_out_if.source  out_bus
);

  cell_ctl_t ctl;
  word_t     cell_val [CAPACITY];

  oate_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .head_val (cell_val[0]),
    .ctl      (ctl)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    word_t lower_w, upper_w;
    if (i == 0) begin : g_first
      assign lower_w = cell_val[0];
    end else begin : g_mid_lo
      assign lower_w = cell_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign upper_w = cell_val[CAPACITY-1];
    end else begin : g_mid_hi
      assign upper_w = cell_val[i+1];
    end

    oate_cell u_cell (
      .clk       (clk),
      .cell_idx  (IW'(i)),
      .ctl       (ctl),
      .lower_val (lower_w),
      .upper_val (upper_w),
      .wrap_val  (cell_val[0]),
      .val_r     (cell_val[i])
    );
  end

endmodule

/* rtl/oate_cell.sv */
// ----------------------------------------------------------------------------
// oate_cell
// One list entry. Shifts up on insert, down on delete, rotates on scan.
// ----------------------------------------------------------------------------
module oate_cell import oate_pkg::*; (
  input  logic          clk,
  input  logic [IW-1:0] cell_idx,
  input  cell_ctl_t     ctl,
  input  word_t         lower_val,
  input  word_t         upper_val,
  input  word_t         wrap_val,
  output word_t         val_r
);

  word_t val_nxt;

  always_comb begin
    val_nxt = val_r;
    case (ctl.cmd)
      CMD_INS: begin
        if (cell_idx > ctl.pidx) begin
          val_nxt = lower_val;
        end else if (cell_idx == ctl.pidx) begin
          val_nxt = ctl.data;
        end
      end
      CMD_DEL: begin
        if (cell_idx >= ctl.pidx) begin
          val_nxt = upper_val;
        end
      end
      CMD_ROT: begin
        val_nxt = (cell_idx == ctl.last) ? wrap_val : upper_val;
      end
      default: val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

/* rtl/oate_ctrl.sv */
// ----------------------------------------------------------------------------
// oate_ctrl
// Request decode, count, scan sequencer and result register.
// ----------------------------------------------------------------------------
module oate_ctrl import oate_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  oate_in_if.sink     in_bus,
  oate_out_if.source  out_bus,
  input  word_t       head_val,
  output cell_ctl_t   ctl
);

  fsm_t           state_r, state_nxt;
  logic [CW-1:0]  cnt_r;
  logic [IW-1:0]  k_r, last_r, pidx_r;
  word_t          key_r, rd_r;
  logic           is_read_r, found_r;
  logic [CW-1:0]  hit_r;

  logic           out_vld_r;
  status_t        out_status_r;
  logic [7:0]     out_found_r, out_cnt_r;
  word_t          out_rd_r;

  logic           accept, out_fire;
  logic [PW-1:0]  pos_x, cnt_x;
  logic           pos_nz, ins_ok, pos_ok;
  status_t        dec_status;
  logic [CW-1:0]  dec_cnt;
  logic           dec_scan;
  cell_cmd_t      dec_cmd;
  logic [IW-1:0]  dec_pidx;
  logic           scan_hit, read_take, scan_end;
  logic [CW-1:0]  k_pos;

  assign accept   = in_bus.valid && in_bus.ready;
  assign out_fire = out_vld_r && out_bus.ready;

  // request decode
  always_comb begin
    pos_x      = PW'(in_bus.position);
    cnt_x      = PW'(cnt_r);
    pos_nz     = in_bus.position != 8'd0;
    ins_ok     = pos_nz && (pos_x <= cnt_x + PW'(1));
    pos_ok     = pos_nz && (pos_x <= cnt_x);
    dec_pidx   = IW'(pos_x - PW'(1));
    dec_status = STS_OK;
    dec_cnt    = cnt_r;
    dec_scan   = 1'b0;
    dec_cmd    = CMD_HOLD;
    unique case (req_t'(in_bus.req_type))
      REQ_CLEAR: dec_cnt = '0;
      REQ_INSERT: begin
        if (cnt_r == CW'(CAPACITY)) begin
          dec_status = STS_FULL;
        end else if (!ins_ok) begin
          dec_status = STS_RANGE;
        end else begin
          dec_cmd = CMD_INS;
          dec_cnt = cnt_r + CW'(1);
        end
      end
      REQ_DELETE: begin
        if (!pos_ok) begin
          dec_status = STS_RANGE;
        end else begin
          dec_cmd = CMD_DEL;
          dec_cnt = cnt_r - CW'(1);
        end
      end
      REQ_SEARCH: begin
        if (cnt_r == '0) begin
          dec_status = STS_NOTFOUND;
        end else begin
          dec_scan = 1'b1;
        end
      end
      REQ_READ: begin
        if (!pos_ok) begin
          dec_status = STS_RANGE;
        end else begin
          dec_scan = 1'b1;
        end
      end
      default: dec_status = STS_OK;
    endcase
  end

  // scan step: head cell holds logical entry k_r
  assign scan_hit  = !is_read_r && !found_r && (head_val == key_r);
  assign read_take = is_read_r && (k_r == pidx_r);
  assign scan_end  = k_r == last_r;
  assign k_pos     = CW'(k_r) + CW'(1);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept && dec_scan) state_nxt = ST_SCAN;
      ST_SCAN: if (scan_end) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_bus.ready = 1'b0;
    ctl.cmd      = CMD_HOLD;
    ctl.pidx     = dec_pidx;
    ctl.last     = last_r;
    ctl.data     = in_bus.data_value;
    unique case (state_r)
      ST_IDLE: begin
        in_bus.ready = !out_vld_r || out_bus.ready;
        if (accept) ctl.cmd = dec_cmd;
      end
      ST_SCAN: ctl.cmd = CMD_ROT;
      default: ctl.cmd = CMD_HOLD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_IDLE && accept) cnt_r <= dec_cnt;
      if ((state_r == ST_IDLE && accept && !dec_scan) ||
          (state_r == ST_SCAN && scan_end)) begin
        out_vld_r <= 1'b1;
      end else if (out_fire) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept) begin
      k_r       <= '0;
      last_r    <= IW'(cnt_r - CW'(1));
      pidx_r    <= dec_pidx;
      key_r     <= in_bus.data_value;
      is_read_r <= req_t'(in_bus.req_type) == REQ_READ;
      found_r   <= 1'b0;
      hit_r     <= '0;
      rd_r      <= '0;
      if (!dec_scan) begin
        out_status_r <= dec_status;
        out_found_r  <= 8'd0;
        out_rd_r     <= '0;
        out_cnt_r    <= to_byte(dec_cnt);
      end
    end else if (state_r == ST_SCAN) begin
      k_r <= k_r + IW'(1);
      if (scan_hit) begin
        found_r <= 1'b1;
        hit_r   <= k_pos;
      end
      if (read_take) rd_r <= head_val;
      if (scan_end) begin
        out_status_r <= (is_read_r || found_r || scan_hit) ? STS_OK : STS_NOTFOUND;
        out_found_r  <= to_byte(scan_hit ? k_pos : hit_r);
        out_rd_r     <= read_take ? head_val : rd_r;
        out_cnt_r    <= to_byte(cnt_r);
      end
    end
  end

  assign out_bus.valid          = out_vld_r;
  assign out_bus.status         = out_status_r;
  assign out_bus.found_position = out_found_r;
  assign out_bus.read_value     = out_rd_r;
  assign out_bus.element_count  = out_cnt_r;

endmodule

/* verif/tb_ordered_array_table_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_array_table_engine
// Self-checking bench for the ordered array table engine. Request beats are
// queued up front (a directed opener, then random phases that grow the list,
// sometimes to full, work on it and tear it down) and driven with random
// gaps. The list is tracked in the bench at request acceptance; every result
// beat is checked field by field against the oldest predicted result while
// the result side stalls at random.
// ----------------------------------------------------------------------------
module tb_ordered_array_table_engine;
  import oate_pkg::*;

  localparam int ITEMS    = 1350;
  localparam int DRAIN    = 2 * CAPACITY + 10;
  localparam int WATCHDOG = 8 * CAPACITY + 200;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] pos;
    word_t      val;
  } req_beat_t;

  typedef struct packed {
    status_t    status;
    logic [7:0] hit;
    word_t      rd;
    logic [7:0] cnt;
  } rsp_beat_t;

  logic clk;
  logic rst_n;

  oate_in_if  in_bus ();
  oate_out_if out_bus ();

  ordered_array_table_engine dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  always #10 clk = ~clk;

  // list as the block should hold it
  word_t     list_mem [CAPACITY];
  int        list_len;
  int        deepest;

  req_beat_t req_backlog[$];
  rsp_beat_t pending_results[$];
  word_t     shadow[$];
  int        total_reqs;

  req_beat_t drv_beat;
  int        in_gap;
  bit        in_calm;
  int        out_stall;
  bit        out_calm;
  int        beats_in;
  int        beats_out;
  int        errors;
  int        idle_cycles;
  int        n_hit, n_miss, n_range, n_full;

  function automatic rsp_beat_t apply_request(req_beat_t r);
    rsp_beat_t o;
    int        i;
    o.status = STS_OK;
    o.hit    = '0;
    o.rd     = '0;
    case (r.kind)
      REQ_CLEAR: list_len = 0;
      REQ_INSERT: begin
        if (list_len >= CAPACITY) begin
          o.status = STS_FULL;
        end else if (int'(r.pos) < 1 || int'(r.pos) > list_len + 1) begin
          o.status = STS_RANGE;
        end else begin
          for (i = list_len; i > int'(r.pos) - 1; i--) list_mem[i] = list_mem[i-1];
          list_mem[int'(r.pos) - 1] = r.val;
          list_len++;
        end
      end
      REQ_DELETE: begin
        if (int'(r.pos) < 1 || int'(r.pos) > list_len) begin
          o.status = STS_RANGE;
        end else begin
          for (i = int'(r.pos) - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
        end
      end
      REQ_SEARCH: begin
        o.status = STS_NOTFOUND;
        for (i = 0; i < list_len; i++) begin
          if (list_mem[i] == r.val) begin
            o.hit    = 8'(i + 1);
            o.status = STS_OK;
            break;
          end
        end
      end
      REQ_READ: begin
        if (int'(r.pos) < 1 || int'(r.pos) > list_len) o.status = STS_RANGE;
        else o.rd = list_mem[int'(r.pos) - 1];
      end
      default: ;
    endcase
    if (list_len > deepest) deepest = list_len;
    o.cnt = 8'(list_len);
    return o;
  endfunction

  // stimulus side keeps its own view of the list to aim positions and keys
  task automatic queue_req(logic [2:0] kind, logic [7:0] pos, word_t val);
    req_beat_t b;
    b.kind = kind;
    b.pos  = pos;
    b.val  = val;
    req_backlog.push_back(b);
    case (kind)
      REQ_CLEAR: shadow.delete();
      REQ_INSERT:
        if (shadow.size() < CAPACITY && int'(pos) >= 1 && int'(pos) <= shadow.size() + 1)
          shadow.insert(int'(pos) - 1, val);
      REQ_DELETE:
        if (int'(pos) >= 1 && int'(pos) <= shadow.size()) shadow.delete(int'(pos) - 1);
      default: ;
    endcase
  endtask

  function automatic word_t pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 7);
    if (sel < 2) return word_t'($urandom_range(0, 7)) - 4;
    if (sel == 2) return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
    return $urandom;
  endfunction

  task automatic random_op();
    int          n;
    int unsigned sel;
    n   = shadow.size();
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      if (n < CAPACITY) queue_req(REQ_INSERT, 8'($urandom_range(1, n + 1)), pick_value());
      else queue_req(REQ_INSERT, 8'($urandom_range(0, 255)), pick_value());
    end else if (sel < 35) begin
      queue_req(REQ_DELETE, 8'((n > 0) ? $urandom_range(1, n) : 1), $urandom);
    end else if (sel < 55) begin
      queue_req(REQ_SEARCH, 8'($urandom),
                (n > 0) ? shadow[$urandom_range(0, n - 1)] : pick_value());
    end else if (sel < 65) begin
      queue_req(REQ_SEARCH, 8'($urandom), pick_value());
    end else if (sel < 80) begin
      queue_req(REQ_READ, 8'((n > 0) ? $urandom_range(1, n) : $urandom_range(0, 1)),
                $urandom);
    end else begin
      queue_req(3'($urandom_range(1, 7)), 8'($urandom_range(0, 255)), $urandom);
    end
  endtask

  task automatic build_stimulus();
    int  target;
    bit  first;
    queue_req(REQ_SEARCH, 8'd0, 32'sd0);
    queue_req(REQ_READ,   8'd1, 32'sd0);
    queue_req(REQ_DELETE, 8'd1, 32'sd0);
    queue_req(REQ_INSERT, 8'd0, 32'sd5);
    queue_req(REQ_INSERT, 8'd2, 32'sd5);
    queue_req(REQ_INSERT, 8'd1, 32'sh80000000);
    queue_req(REQ_INSERT, 8'd2, 32'sh7fffffff);
    queue_req(REQ_INSERT, 8'd1, -32'sd1);
    queue_req(REQ_INSERT, 8'd4, 32'sd7);
    queue_req(REQ_INSERT, 8'd2, 32'sd7);
    queue_req(REQ_SEARCH, 8'd255, 32'sd7);
    queue_req(REQ_SEARCH, 8'd0, 32'sh7fffffff);
    queue_req(REQ_SEARCH, 8'd0, -32'sd1);
    queue_req(REQ_SEARCH, 8'd0, 32'sd12345);
    queue_req(REQ_READ,   8'd5, 32'sd0);
    queue_req(REQ_READ,   8'd6, 32'sd0);
    queue_req(REQ_READ,   8'd255, 32'sd0);
    queue_req(REQ_DELETE, 8'd255, 32'sd0);
    queue_req(REQ_DELETE, 8'd5, 32'sd0);
    queue_req(REQ_DELETE, 8'd1, 32'sd0);
    queue_req(3'd5, 8'd255, 32'shffffffff);
    queue_req(3'd6, 8'd128, 32'sh55555555);
    queue_req(3'd7, 8'd1, 32'shaaaaaaaa);
    queue_req(REQ_CLEAR, 8'd255, 32'shffffffff);
    queue_req(REQ_READ,  8'd1, 32'sd0);

    first = 1'b1;
    while (req_backlog.size() < ITEMS) begin
      if (first || $urandom_range(0, 5) == 0) target = CAPACITY;
      else target = $urandom_range(1, 24);
      while (shadow.size() < target)
        queue_req(REQ_INSERT, 8'($urandom_range(1, shadow.size() + 1)), pick_value());
      if (first) begin
        queue_req(REQ_INSERT, 8'd0, 32'sd1);
        queue_req(REQ_INSERT, 8'd1, 32'sd1);
        queue_req(REQ_READ, 8'(CAPACITY), 32'sd0);
        queue_req(REQ_READ, 8'(CAPACITY + 1), 32'sd0);
      end
      repeat ($urandom_range(10, 40)) random_op();
      if ($urandom_range(0, 1)) begin
        queue_req(REQ_CLEAR, 8'($urandom), $urandom);
      end else begin
        while (shadow.size() > 0)
          queue_req(REQ_DELETE, 8'($urandom_range(1, shadow.size())), $urandom);
        queue_req(REQ_SEARCH, 8'($urandom), pick_value());
      end
      first = 1'b0;
    end
    while (req_backlog.size() > ITEMS) void'(req_backlog.pop_back());
    total_reqs = req_backlog.size();
  endtask

  function automatic void check_field(string name, logic [31:0] exp, logic [31:0] got);
    if (got !== exp) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h (result beat %0d)",
               $time, name, exp, got, beats_out);
    end
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_gap       <= 0;
    end else if (in_bus.valid && in_bus.ready) begin
      pending_results.push_back(apply_request(drv_beat));
      beats_in++;
      if ($urandom_range(0, 39) == 0) in_calm = !in_calm;
      in_gap <= in_calm ? 0 : $urandom_range(0, 3);
      if ((in_calm || $urandom_range(0, 3) == 0) && req_backlog.size() > 0) begin
        drv_beat = req_backlog.pop_front();
        in_bus.req_type   <= drv_beat.kind;
        in_bus.position   <= drv_beat.pos;
        in_bus.data_value <= drv_beat.val;
        in_bus.valid      <= 1'b1;
      end else begin
        in_bus.valid <= 1'b0;
      end
    end else if (!in_bus.valid) begin
      if (in_gap > 0) begin
        in_gap <= in_gap - 1;
      end else if (req_backlog.size() > 0) begin
        drv_beat = req_backlog.pop_front();
        in_bus.req_type   <= drv_beat.kind;
        in_bus.position   <= drv_beat.pos;
        in_bus.data_value <= drv_beat.val;
        in_bus.valid      <= 1'b1;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    rsp_beat_t exp;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_stall     <= 0;
    end else if (out_bus.valid && out_bus.ready) begin
      beats_out++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, actual status %0d count %0d",
                 $time, out_bus.status, out_bus.element_count);
      end else begin
        exp = pending_results.pop_front();
        check_field("status", 32'(exp.status), 32'(out_bus.status));
        check_field("found_position", 32'(exp.hit), 32'(out_bus.found_position));
        check_field("read_value", exp.rd, out_bus.read_value);
        check_field("element_count", 32'(exp.cnt), 32'(out_bus.element_count));
        case (exp.status)
          STS_RANGE:    n_range++;
          STS_FULL:     n_full++;
          STS_NOTFOUND: n_miss++;
          default:      if (exp.hit != 0) n_hit++;
        endcase
      end
      if ($urandom_range(0, 39) == 0) out_calm = !out_calm;
      if (out_calm || $urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b0;
        out_stall     <= $urandom_range(1, 3);
      end
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      if (out_stall == 1) out_bus.ready <= 1'b1;
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG) begin
      $display("%0t: watchdog, no beat for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_results.size());
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.req_type   = '0;
    in_bus.position   = '0;
    in_bus.data_value = '0;
    out_bus.ready     = 1'b0;
    list_len          = 0;
    deepest           = 0;
    beats_in          = 0;
    beats_out         = 0;
    errors            = 0;
    idle_cycles       = 0;
    in_calm           = 1'b0;
    out_calm          = 1'b0;
    n_hit             = 0;
    n_miss            = 0;
    n_range           = 0;
    n_full            = 0;
    build_stimulus();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    while (beats_in < total_reqs) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Ran %0d requests, checked %0d results; list reached %0d of %0d entries.",
             beats_in, beats_out, deepest, CAPACITY);
    $display("Search hits %0d, misses %0d, range errors %0d, full refusals %0d.",
             n_hit, n_miss, n_range, n_full);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/oate_pkg.sv
rtl/oate_in_if.sv
rtl/oate_out_if.sv
rtl/oate_cell.sv
rtl/oate_ctrl.sv
rtl/ordered_array_table_engine.sv
verif/tb_ordered_array_table_engine.sv
